// ----- src/obrc_pkg.sv -----
// shared constants, types and codes for the occupancy bitmap with rank counts
package obrc_pkg;

	localparam int NODE_SIDE   = 16;
	localparam int MAX_NODES   = 256;
	localparam int NODE_WORDS  = (NODE_SIDE * NODE_SIDE * NODE_SIDE) / 32;
	localparam int TOTAL_WORDS = MAX_NODES * NODE_WORDS;
	localparam int NODE_BITS   = NODE_WORDS * 32;

	localparam int ADDR_W  = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;
	localparam int NODE_AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int WORD_AW = (NODE_WORDS > 1) ? $clog2(NODE_WORDS) : 1;
	localparam int CNT_W   = 13;

	localparam logic [31:0] NODE_WORDS_V = 32'(NODE_WORDS);
	localparam logic [31:0] MAX_NODES_V  = 32'(MAX_NODES);
	localparam logic [31:0] NODE_BITS_V  = 32'(NODE_BITS);
	localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(TOTAL_WORDS - 1);
	localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(NODE_WORDS - 1);

	typedef enum logic [1:0] {
		OP_SET   = 2'd0,
		OP_QUERY = 2'd1,
		OP_CLEAR = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_WALK,
		ST_ZERO,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  node_index;
		logic [11:0] bit_index;
	} cmd_t;

	typedef struct packed {
		logic              was_set;
		logic [31:0]       word_bits;
		logic [CNT_W-1:0]  prefix_count;
		logic [CNT_W-1:0]  child_count;
	} rsp_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [31:0]       wdata;
		logic [ADDR_W-1:0] raddr;
	} bm_req_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CNT_W-1:0]  wdata;
		logic [ADDR_W-1:0] raddr;
	} pf_req_t;

	typedef struct packed {
		logic               we;
		logic [NODE_AW-1:0] waddr;
		logic [CNT_W-1:0]   wdata;
		logic [NODE_AW-1:0] raddr;
	} cc_req_t;

endpackage

// ----- src/occupancy_bitmap_with_rank_counts.sv -----
// top level: occupancy bitmap with per word prefix counts and per node child counts
//
// An item is taken when start is high and busy is low; its result word appears on result for
// one cycle with done high, and the receiver must take it then. The work per item is set by
// the sequencer and the single port pair of each count memory: a query, or a set of a bit
// that is already set, reads and evaluates one word; a set of a clear bit then walks the later
// prefix counts of the node at one word per cycle; a node clear sweeps NODE_WORDS words; an
// item with a bad opcode, node or bit returns an all-zero result without touching memory.
// After reset busy stays high for a clearing pass over all TOTAL_WORDS words.
module occupancy_bitmap_with_rank_counts (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  obrc_pkg::cmd_t  cmd,
	output logic            busy,
	output logic            done,
	output obrc_pkg::rsp_t  result
);

	obrc_pkg::bm_req_t bm_req;
	obrc_pkg::pf_req_t pf_req;
	obrc_pkg::cc_req_t cc_req;

	logic [31:0]                bm_rdata;
	logic [obrc_pkg::CNT_W-1:0] pf_rdata;
	logic [obrc_pkg::CNT_W-1:0] cc_rdata;

	obrc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done),
		.result   (result),
		.bm_req   (bm_req),
		.pf_req   (pf_req),
		.cc_req   (cc_req),
		.bm_rdata (bm_rdata),
		.pf_rdata (pf_rdata),
		.cc_rdata (cc_rdata)
	);

	obrc_ram #(
		.WIDTH (32),
		.DEPTH (obrc_pkg::TOTAL_WORDS)
	) u_bitmap_ram (
		.clk   (clk),
		.we    (bm_req.we),
		.waddr (bm_req.waddr),
		.wdata (bm_req.wdata),
		.raddr (bm_req.raddr),
		.rdata (bm_rdata)
	);

	obrc_ram #(
		.WIDTH (obrc_pkg::CNT_W),
		.DEPTH (obrc_pkg::TOTAL_WORDS)
	) u_prefix_ram (
		.clk   (clk),
		.we    (pf_req.we),
		.waddr (pf_req.waddr),
		.wdata (pf_req.wdata),
		.raddr (pf_req.raddr),
		.rdata (pf_rdata)
	);

	obrc_ram #(
		.WIDTH (obrc_pkg::CNT_W),
		.DEPTH (obrc_pkg::MAX_NODES)
	) u_child_ram (
		.clk   (clk),
		.we    (cc_req.we),
		.waddr (cc_req.waddr),
		.wdata (cc_req.wdata),
		.raddr (cc_req.raddr),
		.rdata (cc_rdata)
	);

endmodule

// ----- src/obrc_ram.sv -----
// generic single write port ram with registered read
module obrc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/obrc_ctrl.sv -----
// sequencer with the shared count incrementer for set, query and clear
module obrc_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  obrc_pkg::cmd_t               cmd,
	output logic                         busy,
	output logic                         done,
	output obrc_pkg::rsp_t               result,
	output obrc_pkg::bm_req_t            bm_req,
	output obrc_pkg::pf_req_t            pf_req,
	output obrc_pkg::cc_req_t            cc_req,
	input  logic [31:0]                  bm_rdata,
	input  logic [obrc_pkg::CNT_W-1:0]   pf_rdata,
	input  logic [obrc_pkg::CNT_W-1:0]   cc_rdata
);

	obrc_pkg::state_t state_q, state_d;

	logic [obrc_pkg::ADDR_W-1:0]  init_addr_q, init_addr_d;
	logic                         pend_q, pend_d;
	logic [obrc_pkg::ADDR_W-1:0]  rd_addr_q, rd_addr_d;
	logic [obrc_pkg::ADDR_W-1:0]  wr_addr_q, wr_addr_d;
	logic [obrc_pkg::WORD_AW-1:0] remain_q, remain_d;
	logic [obrc_pkg::ADDR_W-1:0]  idx_q, base_q;
	logic [obrc_pkg::NODE_AW-1:0] node_q;
	logic [4:0]                   pos_q;
	obrc_pkg::opcode_t            op_q;
	obrc_pkg::rsp_t               res_q, res_d;

	logic                         accept;
	logic                         op_ok, item_ok;
	logic [6:0]                   word_in;
	logic [31:0]                  base_full, idx_full, later_full;
	logic [obrc_pkg::CNT_W-1:0]   inc_in, inc_out;
	logic                         old_bit;
	logic [31:0]                  set_word;

	assign accept  = start && !busy;
	assign word_in = cmd.bit_index[11:5];
	assign op_ok   = (cmd.opcode == obrc_pkg::OP_SET) || (cmd.opcode == obrc_pkg::OP_QUERY)
		|| (cmd.opcode == obrc_pkg::OP_CLEAR);
	assign item_ok = op_ok && ({24'd0, cmd.node_index} < obrc_pkg::MAX_NODES_V)
		&& ({20'd0, cmd.bit_index} < obrc_pkg::NODE_BITS_V);

	assign base_full  = 32'(cmd.node_index) * obrc_pkg::NODE_WORDS_V;
	assign idx_full   = base_full + 32'(word_in);
	assign later_full = obrc_pkg::NODE_WORDS_V - 32'(word_in) - 32'd1;

	// one incrementer serves the child count and every prefix count
	assign inc_in  = (state_q == obrc_pkg::ST_EVAL) ? cc_rdata : pf_rdata;
	assign inc_out = inc_in + obrc_pkg::CNT_W'(1);

	assign old_bit  = bm_rdata[pos_q];
	assign set_word = bm_rdata | (32'd1 << pos_q);

	assign busy   = (state_q != obrc_pkg::ST_IDLE);
	assign done   = (state_q == obrc_pkg::ST_DONE);
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= obrc_pkg::ST_INIT;
			init_addr_q <= '0;
			pend_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			init_addr_q <= init_addr_d;
			pend_q      <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_q <= rd_addr_d;
		wr_addr_q <= wr_addr_d;
		remain_q  <= remain_d;
		res_q     <= res_d;
		if (accept) begin
			idx_q  <= obrc_pkg::ADDR_W'(idx_full);
			base_q <= obrc_pkg::ADDR_W'(base_full);
			node_q <= obrc_pkg::NODE_AW'(32'(cmd.node_index));
			pos_q  <= cmd.bit_index[4:0];
			op_q   <= obrc_pkg::opcode_t'(cmd.opcode);
		end
	end

	always_comb begin
		state_d     = state_q;
		init_addr_d = init_addr_q;
		pend_d      = pend_q;
		rd_addr_d   = rd_addr_q;
		wr_addr_d   = wr_addr_q;
		remain_d    = remain_q;
		res_d       = res_q;
		bm_req       = '0;
		pf_req       = '0;
		cc_req       = '0;
		bm_req.raddr = idx_q;
		pf_req.raddr = idx_q;
		cc_req.raddr = node_q;
		case (state_q)
			obrc_pkg::ST_INIT: begin
				// clearing pass over every word, child counts ride along
				bm_req.we    = 1'b1;
				bm_req.waddr = init_addr_q;
				pf_req.we    = 1'b1;
				pf_req.waddr = init_addr_q;
				cc_req.we    = (32'(init_addr_q) < obrc_pkg::MAX_NODES_V);
				cc_req.waddr = obrc_pkg::NODE_AW'(init_addr_q);
				if (init_addr_q == obrc_pkg::LAST_ADDR) begin
					state_d = obrc_pkg::ST_IDLE;
				end else begin
					init_addr_d = init_addr_q + obrc_pkg::ADDR_W'(1);
				end
			end
			obrc_pkg::ST_IDLE: begin
				if (start) begin
					remain_d = obrc_pkg::WORD_AW'(later_full);
					if (item_ok) begin
						state_d = obrc_pkg::ST_READ;
					end else begin
						res_d   = '0;
						state_d = obrc_pkg::ST_DONE;
					end
				end
			end
			obrc_pkg::ST_READ: begin
				state_d = obrc_pkg::ST_EVAL;
			end
			obrc_pkg::ST_EVAL: begin
				res_d.was_set      = old_bit;
				res_d.word_bits    = bm_rdata;
				res_d.prefix_count = pf_rdata;
				res_d.child_count  = cc_rdata;
				rd_addr_d          = idx_q + obrc_pkg::ADDR_W'(1);
				pend_d             = 1'b0;
				state_d            = obrc_pkg::ST_DONE;
				case (op_q)
					obrc_pkg::OP_SET: begin
						if (!old_bit) begin
							bm_req.we         = 1'b1;
							bm_req.waddr      = idx_q;
							bm_req.wdata      = set_word;
							cc_req.we         = 1'b1;
							cc_req.waddr      = node_q;
							cc_req.wdata      = inc_out;
							res_d.word_bits   = set_word;
							res_d.child_count = inc_out;
							state_d           = obrc_pkg::ST_WALK;
						end
					end
					obrc_pkg::OP_CLEAR: begin
						cc_req.we          = 1'b1;
						cc_req.waddr       = node_q;
						res_d.word_bits    = '0;
						res_d.prefix_count = '0;
						res_d.child_count  = '0;
						rd_addr_d          = base_q;
						remain_d           = obrc_pkg::LAST_WORD;
						state_d            = obrc_pkg::ST_ZERO;
					end
					default: begin
						state_d = obrc_pkg::ST_DONE;
					end
				endcase
			end
			obrc_pkg::ST_WALK: begin
				// read the next later word while writing back the one read last cycle
				pf_req.raddr = rd_addr_q;
				if (pend_q) begin
					pf_req.we    = 1'b1;
					pf_req.waddr = wr_addr_q;
					pf_req.wdata = inc_out;
				end
				if (remain_q != '0) begin
					wr_addr_d = rd_addr_q;
					rd_addr_d = rd_addr_q + obrc_pkg::ADDR_W'(1);
					remain_d  = remain_q - obrc_pkg::WORD_AW'(1);
					pend_d    = 1'b1;
				end else begin
					pend_d  = 1'b0;
					state_d = obrc_pkg::ST_DONE;
				end
			end
			obrc_pkg::ST_ZERO: begin
				bm_req.we    = 1'b1;
				bm_req.waddr = rd_addr_q;
				pf_req.we    = 1'b1;
				pf_req.waddr = rd_addr_q;
				if (remain_q == '0) begin
					state_d = obrc_pkg::ST_DONE;
				end else begin
					rd_addr_d = rd_addr_q + obrc_pkg::ADDR_W'(1);
					remain_d  = remain_q - obrc_pkg::WORD_AW'(1);
				end
			end
			obrc_pkg::ST_DONE: begin
				state_d = obrc_pkg::ST_IDLE;
			end
			default: begin
				state_d = obrc_pkg::ST_IDLE;
			end
		endcase
	end

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted word did not make the block busy");

	a_walk_no_bitmap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == obrc_pkg::ST_WALK) |-> !bm_req.we)
		else $error("bitmap written during prefix walk");

	a_zero_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == obrc_pkg::ST_ZERO) |-> (bm_req.we && pf_req.we && bm_req.wdata == '0
			&& pf_req.wdata == '0))
		else $error("node clear sweep skipped a zero write");

	a_walk_in_node: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == obrc_pkg::ST_WALK && pend_q) |-> (wr_addr_q > idx_q))
		else $error("prefix walk touched a word at or before the set word");

endmodule

// ----- bench/tb.sv -----
// testbench for the occupancy bitmap with rank counts: random bursts checked against a predictor
module tb;

	localparam logic [1:0] OP_BAD = 2'd3;
	localparam int LIMIT = 1_000_000;
	localparam int RANDOM_WORDS = 650;

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	obrc_pkg::cmd_t cmd = '0;
	logic busy;
	logic done;
	obrc_pkg::rsp_t result;

	// predictor state
	logic [31:0]                bitmap_mem [obrc_pkg::TOTAL_WORDS];
	logic [obrc_pkg::CNT_W-1:0] prefix_mem [obrc_pkg::TOTAL_WORDS];
	logic [obrc_pkg::CNT_W-1:0] child_mem  [obrc_pkg::MAX_NODES];

	obrc_pkg::cmd_t pending_words [$];
	obrc_pkg::rsp_t expected_words [$];

	int mismatches = 0;
	int burst_left = 0;
	int gap_left = 0;
	int cycles = 0;

	occupancy_bitmap_with_rank_counts u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// applies one command word to the predicted bitmap and returns the result word
	function automatic obrc_pkg::rsp_t apply_to_bitmap(obrc_pkg::cmd_t c);
		obrc_pkg::rsp_t r;
		int unsigned wrd;
		int unsigned pos;
		int unsigned base;
		int unsigned idx;
		int unsigned i;
		logic hit;
		r = '0;
		if (c.opcode > obrc_pkg::OP_CLEAR || int'(c.node_index) >= obrc_pkg::MAX_NODES
				|| int'(c.bit_index) >= obrc_pkg::NODE_BITS) begin
			return r;
		end
		wrd  = c.bit_index >> 5;
		pos  = c.bit_index & 31;
		base = c.node_index * obrc_pkg::NODE_WORDS;
		idx  = base + wrd;
		hit  = bitmap_mem[idx][pos];
		if (c.opcode == obrc_pkg::OP_SET && !hit) begin
			bitmap_mem[idx][pos] = 1'b1;
			// every later word of the node sees one more bit ahead of it
			for (i = idx + 1; i < base + obrc_pkg::NODE_WORDS; i++)
				prefix_mem[i] = prefix_mem[i] + 1'b1;
			child_mem[c.node_index] = child_mem[c.node_index] + 1'b1;
		end else if (c.opcode == obrc_pkg::OP_CLEAR) begin
			for (i = base; i < base + obrc_pkg::NODE_WORDS; i++) begin
				bitmap_mem[i] = '0;
				prefix_mem[i] = '0;
			end
			child_mem[c.node_index] = '0;
		end
		r.was_set      = hit;
		r.word_bits    = bitmap_mem[idx];
		r.prefix_count = prefix_mem[idx];
		r.child_count  = child_mem[c.node_index];
		return r;
	endfunction

	task automatic add_word(logic [1:0] op, int node, int bitn);
		obrc_pkg::cmd_t c;
		c.opcode     = op;
		c.node_index = node[7:0];
		c.bit_index  = bitn[11:0];
		pending_words = {pending_words, c};
	endtask

	task automatic flag_word(string why, obrc_pkg::rsp_t want, obrc_pkg::rsp_t got);
		if (mismatches < 10)
			$display("%0t %s: exp set=%0b word=%h pfx=%0d cnt=%0d, got %0b %h %0d %0d",
				$time, why, want.was_set, want.word_bits, want.prefix_count, want.child_count,
				got.was_set, got.word_bits, got.prefix_count, got.child_count);
		mismatches++;
	endtask

	// driver: bursts of words with random gaps, start held until the word is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
		end else begin
			if (start && !busy) begin
				expected_words = {expected_words, apply_to_bitmap(cmd)};
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(12, 1);
					case ($urandom_range(9))
						0, 1, 2: gap_left = 0;
						3: gap_left = $urandom_range(160, 20);
						default: gap_left = $urandom_range(8, 1);
					endcase
				end
			end
			if (start && busy) begin
				// hold the current word
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_words.size() > 0) begin
				start <= 1'b1;
				cmd <= pending_words.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: every result word must match the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_words.size() == 0) begin
				flag_word("unexpected result", '0, result);
			end else begin
				obrc_pkg::rsp_t want;
				want = expected_words.pop_front();
				if (result.was_set !== want.was_set || result.word_bits !== want.word_bits
						|| result.prefix_count !== want.prefix_count
						|| result.child_count !== want.child_count)
					flag_word("mismatch", want, result);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("** occupancy_bitmap_with_rank_counts: FAILED **");
			$finish;
		end
	end

	initial begin
		int hot_nodes [4];
		int n;
		int roll;
		logic [1:0] op;
		int node;
		int bitn;

		foreach (bitmap_mem[i]) begin
			bitmap_mem[i] = '0;
			prefix_mem[i] = '0;
		end
		foreach (child_mem[i])
			child_mem[i] = '0;

		// directed words
		add_word(obrc_pkg::OP_QUERY, 0, 0);
		add_word(obrc_pkg::OP_SET, 0, 0);
		add_word(obrc_pkg::OP_SET, 0, 0);
		add_word(obrc_pkg::OP_SET, 0, 4095);
		add_word(obrc_pkg::OP_SET, 0, 31);
		add_word(obrc_pkg::OP_SET, 0, 32);
		add_word(obrc_pkg::OP_QUERY, 0, 4095);
		add_word(obrc_pkg::OP_QUERY, 0, 64);
		add_word(obrc_pkg::OP_SET, 255, 4095);
		add_word(obrc_pkg::OP_SET, 255, 0);
		add_word(obrc_pkg::OP_QUERY, 255, 2048);
		add_word(OP_BAD, 0, 0);
		add_word(OP_BAD, 255, 4095);
		add_word(obrc_pkg::OP_CLEAR, 0, 0);
		add_word(obrc_pkg::OP_QUERY, 0, 4095);
		add_word(obrc_pkg::OP_CLEAR, 255, 5);
		add_word(obrc_pkg::OP_QUERY, 255, 4095);
		add_word(obrc_pkg::OP_SET, 170, 12'hAAA);
		add_word(obrc_pkg::OP_SET, 85, 12'h555);
		if (obrc_pkg::MAX_NODES < 256)
			add_word(obrc_pkg::OP_QUERY, obrc_pkg::MAX_NODES, 0);
		if (obrc_pkg::NODE_BITS < 4096) begin
			add_word(obrc_pkg::OP_SET, 0, obrc_pkg::NODE_BITS);
			add_word(obrc_pkg::OP_CLEAR, 0, 4095);
		end

		// random words, concentrated on a few nodes and low words so counts build up
		hot_nodes[0] = 0;
		hot_nodes[1] = obrc_pkg::MAX_NODES - 1;
		hot_nodes[2] = $urandom_range(obrc_pkg::MAX_NODES - 1);
		hot_nodes[3] = $urandom_range(obrc_pkg::MAX_NODES - 1);
		for (n = 0; n < RANDOM_WORDS; n++) begin
			roll = $urandom_range(99);
			if (roll < 56)
				op = obrc_pkg::OP_SET;
			else if (roll < 88)
				op = obrc_pkg::OP_QUERY;
			else if (roll < 93)
				op = obrc_pkg::OP_CLEAR;
			else
				op = OP_BAD;
			if ($urandom_range(99) < 75)
				node = hot_nodes[$urandom_range(3)];
			else
				node = $urandom_range(255);
			if ($urandom_range(99) < 40)
				bitn = $urandom_range(95);
			else
				bitn = $urandom_range(4095);
			add_word(op, node, bitn);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || start)
			@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("** occupancy_bitmap_with_rank_counts: PASSED **");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("** occupancy_bitmap_with_rank_counts: FAILED **");
		end
		$finish;
	end

endmodule

// ----- occupancy_bitmap_with_rank_counts.f -----
src/obrc_pkg.sv
src/obrc_ram.sv
src/obrc_ctrl.sv
src/occupancy_bitmap_with_rank_counts.sv
bench/tb.sv
